FILE: hw/rtl/lbr_pkg.sv
package lbr_pkg;

   localparam int BUFFER_BITS_DEF = 64;
   localparam int FIELD_BITS_DEF  = 32;
   localparam int SKIP_BITS_DEF   = 32;
   localparam int SKIP_FIELD_BITS = 32;
   localparam int VALUE_BITS      = 64;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [2:0] {
      OP_BYTE  = 3'd0,
      OP_FIXED = 3'd1,
      OP_VBR32 = 3'd2,
      OP_VBR64 = 3'd3,
      OP_ALIGN = 3'd4,
      OP_SKIP  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_WIDTH   = 3'd1,
      ST_VBR_LONG    = 3'd2,
      ST_NOT_ALIGNED = 3'd3,
      ST_BUSY        = 3'd4,
      ST_FULL        = 3'd5
   } status_type;

   typedef struct packed {
      op_type                     kind;
      logic                       bad_width;
      logic [7:0]                 data_byte;
      logic [5:0]                 bit_count;
      logic [SKIP_FIELD_BITS-1:0] skip_count;
   } queue_item_type;

endpackage

FILE: hw/rtl/lbr_front.sv
module lbr_front
   import lbr_pkg::*;
#(
   parameter int FIELD_BITS = FIELD_BITS_DEF
) (
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [47:0]    req_tdata,   // data_byte, bit_count, skip_count
   input  logic [2:0]     req_tuser,   // operation
   input  logic           q_full,
   output logic           q_push,
   output queue_item_type q_item
);

   logic [5:0] width;
   logic       keep;

   assign width      = req_tdata[13:8];
   assign req_tready = !q_full;

   always_comb begin
      keep             = 1'b1;
      q_item.kind      = OP_BYTE;
      q_item.bad_width = 1'b0;
      q_item.data_byte = req_tdata[7:0];
      q_item.bit_count = width;
      q_item.skip_count = req_tdata[45:14];
      unique case (req_tuser)
         OP_BYTE: begin
            q_item.kind = OP_BYTE;
         end
         OP_FIXED: begin
            q_item.kind      = OP_FIXED;
            q_item.bad_width = (width == 6'd0) || (width > 6'(FIELD_BITS));
         end
         OP_VBR32, OP_VBR64: begin
            q_item.kind      = op_type'(req_tuser);
            q_item.bad_width = (width < 6'd2) || (width > 6'(FIELD_BITS));
         end
         OP_ALIGN: begin
            q_item.kind = OP_ALIGN;
         end
         OP_SKIP: begin
            q_item.kind = OP_SKIP;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = req_tvalid && !q_full && keep;

endmodule

FILE: hw/rtl/lbr_fifo.sv
module lbr_fifo
   import lbr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  queue_item_type push_item,
   input  logic           pop,
   output queue_item_type head_item,
   output logic           full,
   output logic           not_empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_item_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/lbr_back.sv
module lbr_back
   import lbr_pkg::*;
#(
   parameter int BUFFER_BITS = BUFFER_BITS_DEF,
   parameter int FIELD_BITS  = FIELD_BITS_DEF,
   parameter int SKIP_BITS   = SKIP_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  queue_item_type        q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [VALUE_BITS-1:0] rsp_value,
   output status_type            rsp_status
);

   localparam int FILL_W = $clog2(BUFFER_BITS + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADV,
      S_SKIP
   } state_type;

   typedef enum logic [2:0] {
      PEND_NONE,
      PEND_FIXED,
      PEND_VBR32,
      PEND_VBR64,
      PEND_ALIGN
   } pend_type;

   state_type              state_ff, state_in;
   pend_type               pend_ff, pend_in;
   logic [BUFFER_BITS-1:0] buf_ff, buf_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [5:0]             pw_ff, pw_in;
   logic [VALUE_BITS-1:0]  acc_ff, acc_in;
   logic [6:0]             vshift_ff, vshift_in;
   logic [4:0]             pos_ff, pos_in;
   logic [SKIP_BITS-1:0]   skip_rem_ff, skip_rem_in;
   logic [SKIP_BITS-1:0]   skip_n_ff, skip_n_in;
   logic                   out_valid_ff, out_valid_in;
   logic [VALUE_BITS-1:0]  out_value_ff, out_value_in;
   status_type             out_status_ff, out_status_in;

   // shared take unit
   logic [5:0]             tk_n;
   logic [FIELD_BITS-1:0]  tk_field;
   logic [BUFFER_BITS-1:0] tk_buf;
   logic [FIELD_BITS-1:0]  chunk_shr;
   logic [FIELD_BITS-1:0]  payload;
   logic [VALUE_BITS-1:0]  acc_new;
   logic [7:0]             vs_sum;
   logic [7:0]             vs_limit;
   logic [SKIP_BITS:0]     skip_sum;
   logic                   out_free;

   assign tk_n      = (state_ff == S_SKIP) ? 6'd8 : pw_ff;
   assign tk_field  = buf_ff[FIELD_BITS-1:0] & ~({FIELD_BITS{1'b1}} << tk_n);
   assign tk_buf    = buf_ff >> tk_n;
   assign chunk_shr = tk_field >> (pw_ff - 6'd1);
   assign payload   = tk_field & ~({FIELD_BITS{1'b1}} << (pw_ff - 6'd1));
   assign acc_new   = acc_ff | (VALUE_BITS'(payload) << vshift_ff);
   assign vs_sum    = {1'b0, vshift_ff} + 8'(pw_ff - 6'd1);
   assign vs_limit  = ((pend_ff == PEND_VBR32) ? 8'd32 : 8'd64) - 8'(pw_ff - 6'd1);
   assign skip_sum  = {1'b0, skip_rem_ff} + {1'b0, skip_n_ff};
   assign out_free  = !out_valid_ff || rsp_tready;
   assign q_pop     = (state_ff == S_IDLE) && q_valid && out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_value  = out_value_ff;
   assign rsp_status = out_status_ff;

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      buf_in        = buf_ff;
      fill_in       = fill_ff;
      pw_in         = pw_ff;
      acc_in        = acc_ff;
      vshift_in     = vshift_ff;
      pos_in        = pos_ff;
      skip_rem_in   = skip_rem_ff;
      skip_n_in     = skip_n_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (q_pop) begin
               if (q_item.kind == OP_BYTE) begin
                  if (skip_rem_ff != '0) begin
                     skip_rem_in = skip_rem_ff - 1'b1;
                     pos_in      = pos_ff + 5'd8;
                  end else if (fill_ff > FILL_W'(BUFFER_BITS - 8)) begin
                     out_valid_in  = 1'b1;
                     out_value_in  = '0;
                     out_status_in = ST_FULL;
                  end else begin
                     buf_in   = buf_ff | (BUFFER_BITS'(q_item.data_byte) << fill_ff);
                     fill_in  = fill_ff + FILL_W'(8);
                     state_in = S_ADV;
                  end
               end else if (pend_ff != PEND_NONE) begin
                  out_valid_in  = 1'b1;
                  out_value_in  = '0;
                  out_status_in = ST_BUSY;
               end else begin
                  unique case (q_item.kind)
                     OP_FIXED, OP_VBR32, OP_VBR64: begin
                        if (q_item.bad_width) begin
                           out_valid_in  = 1'b1;
                           out_value_in  = '0;
                           out_status_in = ST_BAD_WIDTH;
                        end else begin
                           pend_in   = (q_item.kind == OP_FIXED) ? PEND_FIXED :
                                       (q_item.kind == OP_VBR32) ? PEND_VBR32 : PEND_VBR64;
                           pw_in     = q_item.bit_count;
                           acc_in    = '0;
                           vshift_in = '0;
                           state_in  = S_ADV;
                        end
                     end
                     OP_ALIGN: begin
                        if (pos_ff == 5'd0) begin
                           out_valid_in  = 1'b1;
                           out_value_in  = '0;
                           out_status_in = ST_OK;
                        end else begin
                           pend_in  = PEND_ALIGN;
                           pw_in    = 6'd32 - {1'b0, pos_ff};
                           state_in = S_ADV;
                        end
                     end
                     OP_SKIP: begin
                        if (fill_ff[2:0] != 3'd0) begin
                           out_valid_in  = 1'b1;
                           out_value_in  = '0;
                           out_status_in = ST_NOT_ALIGNED;
                        end else begin
                           skip_n_in = q_item.skip_count[SKIP_BITS-1:0];
                           state_in  = S_SKIP;
                        end
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end
         S_ADV: begin
            state_in = S_IDLE;
            if ((pend_ff != PEND_NONE) && (fill_ff >= FILL_W'(pw_ff))) begin
               buf_in  = tk_buf;
               fill_in = fill_ff - FILL_W'(pw_ff);
               pos_in  = pos_ff + pw_ff[4:0];
               if ((pend_ff == PEND_FIXED) || (pend_ff == PEND_ALIGN)) begin
                  out_valid_in  = 1'b1;
                  out_value_in  = (pend_ff == PEND_FIXED) ? VALUE_BITS'(tk_field) : '0;
                  out_status_in = ST_OK;
                  pend_in       = PEND_NONE;
               end else if (!chunk_shr[0]) begin
                  out_valid_in  = 1'b1;
                  out_value_in  = (pend_ff == PEND_VBR32) ?
                                  {32'd0, acc_new[31:0]} : acc_new;
                  out_status_in = ST_OK;
                  pend_in       = PEND_NONE;
                  acc_in        = '0;
                  vshift_in     = '0;
               end else if (vs_sum > vs_limit) begin
                  out_valid_in  = 1'b1;
                  out_value_in  = '0;
                  out_status_in = ST_VBR_LONG;
                  pend_in       = PEND_NONE;
                  acc_in        = '0;
                  vshift_in     = '0;
               end else begin
                  acc_in    = acc_new;
                  vshift_in = vs_sum[6:0];
                  state_in  = S_ADV;
               end
            end
         end
         S_SKIP: begin
            if ((skip_n_ff != '0) && (fill_ff >= FILL_W'(8))) begin
               buf_in    = tk_buf;
               fill_in   = fill_ff - FILL_W'(8);
               pos_in    = pos_ff + 5'd8;
               skip_n_in = skip_n_ff - 1'b1;
            end else begin
               skip_rem_in   = skip_sum[SKIP_BITS] ? '1 : skip_sum[SKIP_BITS-1:0];
               out_valid_in  = 1'b1;
               out_value_in  = '0;
               out_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pw_ff         <= pw_in;
      skip_n_ff     <= skip_n_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= PEND_NONE;
         buf_ff       <= '0;
         fill_ff      <= '0;
         acc_ff       <= '0;
         vshift_ff    <= '0;
         pos_ff       <= '0;
         skip_rem_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         buf_ff       <= buf_in;
         fill_ff      <= fill_in;
         acc_ff       <= acc_in;
         vshift_ff    <= vshift_in;
         pos_ff       <= pos_in;
         skip_rem_ff  <= skip_rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: hw/rtl/lsb_bit_reader_vbr_core.sv
// Result path: an item answered at once is registered to the output on accept; one that
// reads the bit buffer passes through the S_ADV state first. Results come later while a
// command waits for bytes, walks VBR chunks or drops buffered bytes of a skip, or while
// earlier items sit in the queue. A new item is taken only when idle with the output free;
// a stored byte, buffer read or skip, or a stalled result, holds off the next item.
// Reset: synchronous, active high; clears bit buffer, queue, output.
module lsb_bit_reader_vbr_core
   import lbr_pkg::*;
#(
   parameter int BUFFER_BITS = BUFFER_BITS_DEF,
   parameter int FIELD_BITS  = FIELD_BITS_DEF,
   parameter int SKIP_BITS   = SKIP_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // data_byte[7:0], bit_count[13:8], skip_count[45:14]
   input  logic [2:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // value
   output logic [2:0]  rsp_tuser    // status
);

   queue_item_type push_item;
   queue_item_type head_item;
   logic           q_push;
   logic           q_pop;
   logic           q_full;
   logic           q_not_empty;
   status_type     status;

   lbr_front #(
      .FIELD_BITS(FIELD_BITS)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   lbr_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_item(push_item),
      .pop      (q_pop),
      .head_item(head_item),
      .full     (q_full),
      .not_empty(q_not_empty)
   );

   lbr_back #(
      .BUFFER_BITS(BUFFER_BITS),
      .FIELD_BITS (FIELD_BITS),
      .SKIP_BITS  (SKIP_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_item    (head_item),
      .q_pop     (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_value (rsp_tdata),
      .rsp_status(status)
   );

   assign rsp_tuser = status;

endmodule

FILE: hw/rtl/lbr_checker.sv
module lbr_checker
   import lbr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_FULL)
      else $error("status code out of range");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == 64'd0)
      else $error("error result carries a value");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown right after reset");

endmodule

bind lsb_bit_reader_vbr_core lbr_checker u_lbr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
